// ===== rtl/csv_field_splitter_core_macros.svh =====
// Assertion helpers for the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define CSVFS_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csv field splitter check failed");

// Clocked assertion on the block's own clock and reset.
`define CSVFS_ASSERT(lbl, prop) \
    `CSVFS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== rtl/csvfs_pkg.sv =====
`timescale 1ns / 1ps
package csvfs_pkg;

    localparam int unsigned HOLD_DEPTH_DEF = 16;

    localparam logic OP_EOL = 1'b1;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // datapath -> controller
    typedef struct packed {
        logic need_flush;
        logic flush_last;
        logic has_tail;
        logic out_free;
    } t_dp_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic flush_step;
        logic tail_step;
    } t_ctl_cmd;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/csvfs_if.sv =====
`timescale 1ns / 1ps
interface csvfs_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_byte;

    modport source (output valid, output op, output char_byte, input ready);
    modport sink   (input valid, input op, input char_byte, output ready);
endinterface

interface csvfs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_done;
    logic       line_done;
    logic       space_dropped;
    logic       last_of_run;

    modport source (output valid, output out_char, output char_valid, output field_done,
                    output line_done, output space_dropped, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid, input field_done,
                    input line_done, input space_dropped, input last_of_run,
                    output ready);
endinterface

// ===== rtl/csvfs_datapath.sv =====
`timescale 1ns / 1ps
module csvfs_datapath #(
    parameter int unsigned HOLD_DEPTH = csvfs_pkg::HOLD_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op,
    input  logic [7:0]            i_char_byte,
    input  csvfs_pkg::t_ctl_cmd   i_cmd,
    input  logic                  i_rsp_ready,
    output csvfs_pkg::t_dp_status o_status,
    output logic                  o_rsp_valid,
    output logic [7:0]            o_out_char,
    output logic                  o_char_valid,
    output logic                  o_field_done,
    output logic                  o_line_done,
    output logic                  o_space_dropped,
    output logic                  o_last_of_run
);

    localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
    localparam int unsigned AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // field and quote state
    logic          r_in_quotes, n_in_quotes;
    logic          r_pend, n_pend;
    logic          r_quoted, n_quoted;
    logic          r_content, n_content;
    logic [CW-1:0] r_count;
    logic          r_ovf;

    // hold buffer and release bookkeeping
    logic [7:0]    r_held [HOLD_DEPTH];
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]    r_rd_data;
    logic          r_lost;
    logic          r_tail;
    logic [7:0]    r_tail_char;

    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_cv, r_out_fd, r_out_ld, r_out_sd, r_out_last;

    logic          inq_eff;
    logic          hold_wr, ovf_set, field_end, rel, rel_tail;
    logic          imm_emit, imm_cv, imm_fd, imm_ld;
    logic [7:0]    imm_char;
    logic [CW-1:0] cnt_m1;
    logic          flush_last, out_free, held_any;

    assign held_any   = (r_count != '0);
    assign cnt_m1     = r_count - CW'(1);
    assign flush_last = (r_rd_idx == cnt_m1[AW-1:0]);
    assign out_free   = !r_out_valid || i_rsp_ready;

    // decode one request against the current field state
    always_comb begin
        inq_eff     = r_in_quotes & ~r_pend;
        n_in_quotes = inq_eff;
        n_pend      = 1'b0;
        n_quoted    = r_quoted;
        n_content   = r_content;
        hold_wr     = 1'b0;
        ovf_set     = 1'b0;
        field_end   = 1'b0;
        rel         = 1'b0;
        rel_tail    = 1'b0;
        imm_emit    = 1'b0;
        imm_char    = i_char_byte;
        imm_cv      = 1'b1;
        imm_fd      = 1'b0;
        imm_ld      = 1'b0;
        if (i_op == csvfs_pkg::OP_EOL) begin
            n_in_quotes = 1'b0;
            n_quoted    = 1'b0;
            n_content   = 1'b0;
            field_end   = 1'b1;
            imm_emit    = 1'b1;
            imm_char    = '0;
            imm_cv      = 1'b0;
            imm_fd      = 1'b1;
            imm_ld      = 1'b1;
        end else if (r_pend && (i_char_byte == csvfs_pkg::CH_DQUOTE)) begin
            // doubled quote: literal quote, stay quoted
            n_in_quotes = r_in_quotes;
            n_content   = 1'b1;
            imm_emit    = 1'b1;
        end else if (i_char_byte == csvfs_pkg::CH_DQUOTE) begin
            if (inq_eff) begin
                n_pend      = 1'b1;
                n_in_quotes = 1'b1;
            end else begin
                n_in_quotes = 1'b1;
                n_quoted    = 1'b1;
                rel         = 1'b1;
            end
        end else if ((i_char_byte == csvfs_pkg::CH_COMMA) && !inq_eff) begin
            n_quoted  = 1'b0;
            n_content = 1'b0;
            field_end = 1'b1;
            imm_emit  = 1'b1;
            imm_char  = '0;
            imm_cv    = 1'b0;
            imm_fd    = 1'b1;
        end else if (inq_eff || r_quoted) begin
            n_content = 1'b1;
            imm_emit  = 1'b1;
        end else if (csvfs_pkg::is_ws(i_char_byte)) begin
            if (r_content) begin
                if (r_count < CW'(HOLD_DEPTH)) begin
                    hold_wr = 1'b1;
                end else begin
                    ovf_set = 1'b1;
                end
            end
        end else begin
            n_content = 1'b1;
            rel       = 1'b1;
            rel_tail  = 1'b1;
            // nothing held: the character goes out at once
            imm_emit  = !held_any;
        end
    end

    always_comb begin
        o_status.need_flush = rel && held_any;
        o_status.flush_last = flush_last;
        o_status.has_tail   = r_tail;
        o_status.out_free   = out_free;
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.flush_step) begin
            n_rd_idx = flush_last ? '0 : r_rd_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes <= 1'b0;
            r_pend      <= 1'b0;
            r_quoted    <= 1'b0;
            r_content   <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_idx    <= '0;
            r_tail      <= 1'b0;
            r_lost      <= 1'b0;
        end else begin
            r_rd_idx <= n_rd_idx;
            if (i_cmd.accept) begin
                r_in_quotes <= n_in_quotes;
                r_pend      <= n_pend;
                r_quoted    <= n_quoted;
                r_content   <= n_content;
                if (field_end) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (hold_wr) begin
                    r_count <= r_count + CW'(1);
                end else if (ovf_set) begin
                    r_ovf <= 1'b1;
                end
                if (rel && held_any) begin
                    r_lost <= r_ovf;
                    r_tail <= rel_tail;
                end
            end
            // release done: buffer empty, loss flag spent
            if (i_cmd.flush_step && flush_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // hold buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && hold_wr) begin
            r_held[r_count[AW-1:0]] <= i_char_byte;
        end
        r_rd_data <= r_held[n_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && rel) begin
            r_tail_char <= i_char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (i_cmd.accept && imm_emit) || i_cmd.flush_step || i_cmd.tail_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (i_cmd.flush_step) begin
                r_out_char <= r_rd_data;
                r_out_cv   <= 1'b1;
                r_out_fd   <= 1'b0;
                r_out_ld   <= 1'b0;
                r_out_sd   <= r_lost;
                r_out_last <= flush_last && !r_tail;
            end else if (i_cmd.tail_step) begin
                r_out_char <= r_tail_char;
                r_out_cv   <= 1'b1;
                r_out_fd   <= 1'b0;
                r_out_ld   <= 1'b0;
                r_out_sd   <= r_lost;
                r_out_last <= 1'b1;
            end else begin
                r_out_char <= imm_char;
                r_out_cv   <= imm_cv;
                r_out_fd   <= imm_fd;
                r_out_ld   <= imm_ld;
                r_out_sd   <= 1'b0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_char_valid    = r_out_cv;
    assign o_field_done    = r_out_fd;
    assign o_line_done     = r_out_ld;
    assign o_space_dropped = r_out_sd;
    assign o_last_of_run   = r_out_last;

endmodule

// ===== rtl/csvfs_ctrl.sv =====
`timescale 1ns / 1ps
module csvfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  csvfs_pkg::t_dp_status i_status,
    output logic                  o_req_ready,
    output csvfs_pkg::t_ctl_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_req_ready      = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.flush_step = 1'b0;
        o_cmd.tail_step  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready  = i_status.out_free;
                o_cmd.accept = i_req_valid && i_status.out_free;
                if (o_cmd.accept && i_status.need_flush) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush_step = 1'b1;
                    if (i_status.flush_last) begin
                        n_state = i_status.has_tail ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.tail_step = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/csv_field_splitter_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// i_req     in   sink     op, char_byte
// o_rsp     out  source   out_char, char_valid, field_done, line_done,
//                         space_dropped, last_of_run
//
// Order: a request that gives at most one result writes the result register.
//   A request that releases n held whitespace bytes is accepted, then the n
//   bytes go out, then the content character that triggered it, if any; the
//   single hold read port sets one byte per cycle while o_rsp is not stalled.
// Reset: synchronous, active low; clears quote, field and handshake state.
//   The hold buffer is not cleared; entries are read only after being written.
// Stalls: o_rsp ready low holds the result register; i_req ready drops while
//   that register is full and not taken, and during a release.
module csv_field_splitter_core #(
    parameter int unsigned HOLD_DEPTH = csvfs_pkg::HOLD_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    csvfs_req_if.sink  i_req,
    csvfs_rsp_if.source o_rsp
);

    csvfs_pkg::t_dp_status status;
    csvfs_pkg::t_ctl_cmd   cmd;
    logic                  req_ready;

    assign i_req.ready = req_ready;

    // Sequencer: accept, release held whitespace, emit the trailing character.
    csvfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (status),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    // Field state, hold buffer and the result register.
    csvfs_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_req.op),
        .i_char_byte     (i_req.char_byte),
        .i_cmd           (cmd),
        .i_rsp_ready     (o_rsp.ready),
        .o_status        (status),
        .o_rsp_valid     (o_rsp.valid),
        .o_out_char      (o_rsp.out_char),
        .o_char_valid    (o_rsp.char_valid),
        .o_field_done    (o_rsp.field_done),
        .o_line_done     (o_rsp.line_done),
        .o_space_dropped (o_rsp.space_dropped),
        .o_last_of_run   (o_rsp.last_of_run)
    );

endmodule

// ===== rtl/csvfs_checker.sv =====
`timescale 1ns / 1ps
`include "csv_field_splitter_core_macros.svh"
module csvfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_req_op,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_line_done,
    input logic i_rsp_last_of_run
);

    logic eol_taken;

    assign eol_taken = i_req_valid && i_req_ready && (i_req_op == csvfs_pkg::OP_EOL);

    // a stalled result stays offered
    `CSVFS_ASSERT(a_rsp_hold, (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)

    // end of line shows up as a line-end result on the next cycle
    `CSVFS_ASSERT(a_eol_next, eol_taken |=> (i_rsp_valid && i_rsp_line_done))

    // no new request while a run of results is still going out
    `CSVFS_ASSERT(a_busy_mid_run, (i_rsp_valid && !i_rsp_last_of_run) |-> !i_req_ready)

endmodule

bind csv_field_splitter_core csvfs_checker u_csvfs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_op          (i_req.op),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_line_done   (o_rsp.line_done),
    .i_rsp_last_of_run (o_rsp.last_of_run)
);

// ===== dv/csvfs_checker.sv =====
`timescale 1ns / 1ps
module csvfs_scoreboard #(
    parameter int unsigned HOLD_DEPTH = csvfs_pkg::HOLD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic       i_req_op,
    input  logic [7:0] i_req_char,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  logic [7:0] i_rsp_out_char,
    input  logic       i_rsp_char_valid,
    input  logic       i_rsp_field_done,
    input  logic       i_rsp_line_done,
    input  logic       i_rsp_space_dropped,
    input  logic       i_rsp_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_done;
        logic       line_done;
        logic       space_dropped;
        logic       last_of_run;
    } t_field_result;

    // Splitter state as seen from outside.
    logic        quoted_now;
    logic        close_pending;
    logic        field_is_quoted;
    logic        field_started;
    logic [7:0]  hold_buf [HOLD_DEPTH];
    int unsigned hold_cnt;
    logic        hold_lost;

    t_field_result step_q[$];
    t_field_result field_results_q[$];
    int            fail_count;
    int            pending;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic t_field_result make_result(input logic [7:0] ch, input logic cv,
                                                  input logic fd, input logic ld);
        t_field_result r;
        r.out_char      = ch;
        r.char_valid    = cv;
        r.field_done    = fd;
        r.line_done     = ld;
        r.space_dropped = 1'b0;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Append one result to this step's run.
    function automatic void add_step(input t_field_result r);
        step_q = {step_q, r};
    endfunction

    function automatic void close_field();
        field_is_quoted = 1'b0;
        field_started   = 1'b0;
        hold_cnt        = 0;
        hold_lost       = 1'b0;
    endfunction

    // Emit all held blanks; report whether some were lost to overflow.
    function automatic logic flush_hold();
        logic lost;
        lost = hold_lost && (hold_cnt != 0);
        for (int k = 0; k < hold_cnt; k++)
            add_step(make_result(hold_buf[k], 1'b1, 1'b0, 1'b0));
        hold_cnt  = 0;
        hold_lost = 1'b0;
        return lost;
    endfunction

    task automatic split_char(input logic op, input logic [7:0] c);
        logic          lost;
        logic          blank;
        t_field_result r;
        lost  = 1'b0;
        blank = (c == csvfs_pkg::CH_SPACE) ||
                (c >= csvfs_pkg::CH_TAB && c <= csvfs_pkg::CH_CR);
        step_q.delete();
        if (op == csvfs_pkg::OP_EOL) begin
            quoted_now    = 1'b0;
            close_pending = 1'b0;
            close_field();
            add_step(make_result(8'h00, 1'b0, 1'b1, 1'b1));
        end else if (close_pending && c == csvfs_pkg::CH_DQUOTE) begin
            // doubled quote inside quotes: one literal quote
            close_pending = 1'b0;
            field_started = 1'b1;
            add_step(make_result(csvfs_pkg::CH_DQUOTE, 1'b1, 1'b0, 1'b0));
        end else begin
            if (close_pending) begin
                close_pending = 1'b0;
                quoted_now    = 1'b0;
            end
            if (c == csvfs_pkg::CH_DQUOTE) begin
                if (quoted_now) begin
                    close_pending = 1'b1;
                end else begin
                    quoted_now      = 1'b1;
                    field_is_quoted = 1'b1;
                    lost            = flush_hold();
                end
            end else if (c == csvfs_pkg::CH_COMMA && !quoted_now) begin
                close_field();
                add_step(make_result(8'h00, 1'b0, 1'b1, 1'b0));
            end else if (quoted_now || field_is_quoted) begin
                field_started = 1'b1;
                add_step(make_result(c, 1'b1, 1'b0, 1'b0));
            end else if (blank) begin
                if (field_started) begin
                    if (hold_cnt < HOLD_DEPTH) begin
                        hold_buf[hold_cnt] = c;
                        hold_cnt++;
                    end else begin
                        hold_lost = 1'b1;
                    end
                end
            end else begin
                lost          = flush_hold();
                field_started = 1'b1;
                add_step(make_result(c, 1'b1, 1'b0, 1'b0));
            end
        end
        foreach (step_q[k]) begin
            r               = step_q[k];
            r.space_dropped = lost;
            r.last_of_run   = (k == step_q.size() - 1);
            field_results_q = {field_results_q, r};
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_field_result exp_r;
        if (!i_rst_n) begin
            quoted_now    = 1'b0;
            close_pending = 1'b0;
            close_field();
            foreach (hold_buf[k]) hold_buf[k] = 8'h00;
            field_results_q.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                split_char(i_req_op, i_req_char);
            if (i_rsp_valid && i_rsp_ready) begin
                if (field_results_q.size() == 0) begin
                    $error("result with none expected: out_char %0d field_done %0d",
                           i_rsp_out_char, i_rsp_field_done);
                    fail_count++;
                end else begin
                    exp_r = field_results_q.pop_front();
                    check_field("out_char", exp_r.out_char, i_rsp_out_char);
                    check_field("char_valid", exp_r.char_valid, i_rsp_char_valid);
                    check_field("field_done", exp_r.field_done, i_rsp_field_done);
                    check_field("line_done", exp_r.line_done, i_rsp_line_done);
                    check_field("space_dropped", exp_r.space_dropped, i_rsp_space_dropped);
                    check_field("last_of_run", exp_r.last_of_run, i_rsp_last_of_run);
                end
            end
        end
        pending = field_results_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int unsigned HOLD_DEPTH  = csvfs_pkg::HOLD_DEPTH_DEF;
    localparam logic        OP_CHAR     = 1'b0;
    localparam int          RANDOM_REQS = 280;
    // Directed part plus random part, split in three idling phases.
    localparam int          PHASE_LEN   = 105;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int          tx_idle_pct = 21;
    int          rx_idle_pct = 85;
    int          req_count   = 0;
    int unsigned cycle_count = 0;
    int          fail_count;
    int          pending;

    csvfs_req_if req_if ();
    csvfs_rsp_if rsp_if ();

    csv_field_splitter_core #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    csvfs_scoreboard #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (req_if.valid),
        .i_req_ready        (req_if.ready),
        .i_req_op           (req_if.op),
        .i_req_char         (req_if.char_byte),
        .i_rsp_valid        (rsp_if.valid),
        .i_rsp_ready        (rsp_if.ready),
        .i_rsp_out_char     (rsp_if.out_char),
        .i_rsp_char_valid   (rsp_if.char_valid),
        .i_rsp_field_done   (rsp_if.field_done),
        .i_rsp_line_done    (rsp_if.line_done),
        .i_rsp_space_dropped(rsp_if.space_dropped),
        .i_rsp_last_of_run  (rsp_if.last_of_run),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Drive result ready; stall at the rate of the current phase.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Send one request: pick the phase, idle at random, then hold valid until taken.
    task automatic send_req(input logic op, input logic [7:0] ch);
        if (req_count < PHASE_LEN) begin
            tx_idle_pct = 21;
            rx_idle_pct = 85;
        end else if (req_count < 2 * PHASE_LEN) begin
            tx_idle_pct = 85;
            rx_idle_pct = 21;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.char_byte <= ch;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        req_count++;
    endtask

    // Any whitespace byte: tab, newline, vertical tab, form feed, return or space.
    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? csvfs_pkg::CH_SPACE : csvfs_pkg::CH_TAB + 8'(pick);
    endfunction

    // Any byte that is plain content: not blank, not a quote, not a comma.
    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == csvfs_pkg::CH_DQUOTE || c == csvfs_pkg::CH_COMMA ||
                   c == csvfs_pkg::CH_SPACE ||
                   (c >= csvfs_pkg::CH_TAB && c <= csvfs_pkg::CH_CR));
        return c;
    endfunction

    task automatic send_blanks(input int n);
        for (int k = 0; k < n; k++) send_req(OP_CHAR, rand_blank());
    endtask

    task automatic send_text(input int n);
        for (int k = 0; k < n; k++) send_req(OP_CHAR, rand_text());
    endtask

    // Mostly well-formed lines with random content; some noise and broken fields.
    task automatic send_random_line();
        int  n_fields;
        logic stop;
        stop = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            // raw noise, end of line possible anywhere
            for (int k = 0; k < $urandom_range(1, 8); k++)
                send_req(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields && !stop; f++) begin
                if (f != 0) send_req(OP_CHAR, csvfs_pkg::CH_COMMA);
                case ($urandom_range(0, 9)) inside
                    [0:3]: begin
                        // plain field: leading blanks dropped, inner kept, trailing trimmed
                        send_blanks($urandom_range(0, 2));
                        send_text($urandom_range(1, 4));
                        if ($urandom_range(0, 4) == 0)
                            send_blanks($urandom_range(HOLD_DEPTH - 1, HOLD_DEPTH + 3));
                        else
                            send_blanks($urandom_range(0, 2));
                        if ($urandom_range(0, 1) == 1) send_text($urandom_range(1, 3));
                        send_blanks($urandom_range(0, 3));
                    end
                    [4:6]: begin
                        // quoted field, maybe after content and held blanks
                        send_blanks($urandom_range(0, 1));
                        if ($urandom_range(0, 3) == 0) begin
                            send_text(1);
                            send_blanks($urandom_range(1, HOLD_DEPTH + 2));
                        end
                        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
                        for (int k = 0; k < $urandom_range(0, 6); k++) begin
                            case ($urandom_range(0, 3))
                                0: send_text(1);
                                1: send_blanks(1);
                                2: send_req(OP_CHAR, csvfs_pkg::CH_COMMA);
                                default: begin
                                    send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
                                    send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
                                end
                            endcase
                        end
                        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
                        if ($urandom_range(0, 3) == 0) begin
                            send_blanks($urandom_range(0, 2));
                            send_text($urandom_range(0, 2));
                        end
                    end
                    7: ; // empty field
                    8: begin
                        for (int k = 0; k < $urandom_range(1, 6); k++)
                            send_req(OP_CHAR, 8'($urandom_range(0, 255)));
                    end
                    default: begin
                        // unterminated quote: the line ends inside it
                        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
                        send_text($urandom_range(0, 3));
                        send_blanks($urandom_range(0, 1));
                        stop = 1'b1;
                    end
                endcase
            end
        end
        send_req(csvfs_pkg::OP_EOL, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int directed_reqs;
        req_if.valid     <= 1'b0;
        req_if.op        <= OP_CHAR;
        req_if.char_byte <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Leading blank dropped, extreme bytes, comma, then an opened quote with a
        // doubled quote inside that the end of line leaves unterminated.
        send_req(OP_CHAR, csvfs_pkg::CH_SPACE);
        send_req(OP_CHAR, 8'h00);
        send_req(OP_CHAR, 8'hFF);
        send_req(OP_CHAR, csvfs_pkg::CH_COMMA);
        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
        send_req(csvfs_pkg::OP_EOL, 8'hFF);

        // Overflow the blank hold, release it with a quote in an unquoted field,
        // then close the quotes by a pending close followed by a comma.
        send_req(OP_CHAR, 8'h61);
        for (int k = 0; k <= HOLD_DEPTH; k++)
            send_req(OP_CHAR, (k % 6 == 5) ? csvfs_pkg::CH_SPACE
                                           : csvfs_pkg::CH_TAB + 8'(k % 6));
        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
        send_req(OP_CHAR, csvfs_pkg::CH_DQUOTE);
        send_req(OP_CHAR, csvfs_pkg::CH_COMMA);
        send_req(csvfs_pkg::OP_EOL, 8'h00);

        directed_reqs = req_count;
        while (req_count < directed_reqs + RANDOM_REQS) send_random_line();
        req_if.valid <= 1'b0;

        // Drain, then keep running to catch stray results.
        do @(posedge i_clk); while (pending != 0);
        repeat (HOLD_DEPTH + 8) @(posedge i_clk);

        if (pending != 0)
            $error("%0d field results still expected", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
